FILE: rtl/brl_pkg.sv
`default_nettype none
package brl_pkg;

	// Width of every coordinate field on the channels.
	localparam int unsigned FIELD_W = 6;

	// Default tile size exponent; the tile is 2^COORD_BITS pixels square.
	localparam int unsigned COORD_BITS_DEF = 6;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} brl_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;   // capture a new segment
		logic step;   // advance to the next pixel
	} brl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic last;   // current pixel is the final one
	} brl_sts_t;

endpackage
`default_nettype wire

FILE: rtl/brl_if.sv
`default_nettype none
interface brl_seg_if;
	logic                        valid;
	logic                        ready;
	logic [brl_pkg::FIELD_W-1:0] start_x;
	logic [brl_pkg::FIELD_W-1:0] start_y;
	logic [brl_pkg::FIELD_W-1:0] end_x;
	logic [brl_pkg::FIELD_W-1:0] end_y;

	modport source (output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface brl_pix_if;
	logic                        valid;
	logic                        ready;
	logic [brl_pkg::FIELD_W-1:0] pixel_x;
	logic [brl_pkg::FIELD_W-1:0] pixel_y;
	logic                        last_pixel;

	modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
	modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface
`default_nettype wire

FILE: rtl/brl_ctrl.sv
`default_nettype none
module brl_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire brl_pkg::brl_sts_t sts,
	output brl_pkg::brl_cmd_t      cmd
);
	import brl_pkg::*;

	brl_state_t state_q;
	brl_state_t state_d;
	logic       in_fire;
	logic       out_fire;
	logic       final_beat;

	assign out_valid  = (state_q == ST_RUN);
	assign out_fire   = out_valid && out_ready;
	assign final_beat = out_fire && sts.last;
	// A new segment may load on the beat that drains the last pixel.
	assign in_ready   = (state_q == ST_IDLE) || final_beat;
	assign in_fire    = in_valid && in_ready;

	assign cmd.load = in_fire;
	assign cmd.step = out_fire && !sts.last;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (final_beat) state_d = in_fire ? ST_RUN : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/brl_dp.sv
`default_nettype none
module brl_dp #(
	parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire brl_pkg::brl_cmd_t           cmd,
	output brl_pkg::brl_sts_t                sts,
	input  wire logic [brl_pkg::FIELD_W-1:0] start_x,
	input  wire logic [brl_pkg::FIELD_W-1:0] start_y,
	input  wire logic [brl_pkg::FIELD_W-1:0] end_x,
	input  wire logic [brl_pkg::FIELD_W-1:0] end_y,
	output logic      [brl_pkg::FIELD_W-1:0] pixel_x,
	output logic      [brl_pkg::FIELD_W-1:0] pixel_y,
	output logic                             last_pixel
);
	import brl_pkg::*;

	localparam int unsigned CB = COORD_BITS;
	// Decision term lies within +/- 2*major plus 2*minor.
	localparam int unsigned DW = CB + 3;

	logic [CB-1:0] ax, ay, bx, by;
	logic [CB-1:0] span_x, span_y, major_d, minor_d;
	logic          x_major_d;

	logic [CB-1:0]        cx_q, cy_q, cnt_q, major_q, minor_q;
	logic                 x_major_q, neg_x_q, neg_y_q;
	logic signed [DW-1:0] dec_q;

	logic signed [DW-1:0] two_major, two_minor, dec_init, dec_next;
	logic                 take_minor;
	logic [CB-1:0]        inc_x, inc_y;

	assign ax = start_x[CB-1:0];
	assign ay = start_y[CB-1:0];
	assign bx = end_x[CB-1:0];
	assign by = end_y[CB-1:0];

	assign span_x    = (bx > ax) ? (bx - ax) : (ax - bx);
	assign span_y    = (by > ay) ? (by - ay) : (ay - by);
	assign x_major_d = (span_x >= span_y);
	assign major_d   = x_major_d ? span_x : span_y;
	assign minor_d   = x_major_d ? span_y : span_x;
	assign dec_init  = $signed(DW'({minor_d, 1'b0})) - $signed(DW'(major_d));

	assign two_major  = $signed(DW'({major_q, 1'b0}));
	assign two_minor  = $signed(DW'({minor_q, 1'b0}));
	assign take_minor = !dec_q[DW-1];
	assign dec_next   = dec_q + two_minor - (take_minor ? two_major : DW'(0));

	// +1 or -1 modulo the tile.
	assign inc_x = neg_x_q ? {CB{1'b1}} : CB'(1);
	assign inc_y = neg_y_q ? {CB{1'b1}} : CB'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q      <= ax;
			cy_q      <= ay;
			cnt_q     <= major_d;
			major_q   <= major_d;
			minor_q   <= minor_d;
			x_major_q <= x_major_d;
			neg_x_q   <= !(ax < bx);
			neg_y_q   <= !(ay < by);
			dec_q     <= dec_init;
		end else if (cmd.step) begin
			cnt_q <= cnt_q - CB'(1);
			dec_q <= dec_next;
			if (x_major_q || take_minor) cx_q <= cx_q + inc_x;
			if (!x_major_q || take_minor) cy_q <= cy_q + inc_y;
		end
	end

	assign sts.last   = (cnt_q == '0);
	assign pixel_x    = FIELD_W'(cx_q);
	assign pixel_y    = FIELD_W'(cy_q);
	assign last_pixel = sts.last;

endmodule
`default_nettype wire

FILE: rtl/bresenham_line_rasterizer.sv
// Bresenham line rasterizer.
//
// seg (sink): one line segment per beat, endpoints start_x/start_y and
// end_x/end_y inside a 2^COORD_BITS square tile; upper coordinate bits are
// ignored. pix (source): the pixels of the segment in order from the start
// endpoint, one per beat, last_pixel set on the final one. A segment gives
// its major-axis span plus one pixels, so at most 2^COORD_BITS.
//
// Latency: the first pixel is valid the cycle after the segment beat.
// Throughput: one pixel per cycle while pix.ready is high; the decision
// register and coordinate counters advance as each pixel but the last is
// taken. The next segment is taken on the same beat that delivers the final
// pixel, so segments stream with no gap.
//
// A stalled receiver freezes the current pixel and the walk; seg.ready stays
// low until the final pixel is taken. Reset clears the controller to idle;
// no pixel is offered until a segment arrives.
`default_nettype none
module bresenham_line_rasterizer #(
	parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	brl_seg_if.sink    seg,
	brl_pix_if.source  pix
);
	import brl_pkg::*;

	brl_cmd_t cmd;
	brl_sts_t sts;

	brl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seg.valid),
		.in_ready  (seg.ready),
		.out_valid (pix.valid),
		.out_ready (pix.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	brl_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.sts        (sts),
		.start_x    (seg.start_x),
		.start_y    (seg.start_y),
		.end_x      (seg.end_x),
		.end_y      (seg.end_y),
		.pixel_x    (pix.pixel_x),
		.pixel_y    (pix.pixel_y),
		.last_pixel (pix.last_pixel)
	);

endmodule
`default_nettype wire

FILE: rtl/brl_chk.sv
`default_nettype none
module brl_chk (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [brl_pkg::FIELD_W-1:0] pixel_x,
	input wire logic [brl_pkg::FIELD_W-1:0] pixel_y,
	input wire logic                        last_pixel
);
	import brl_pkg::*;

	// A segment always yields a pixel on the next cycle.
	a_first_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no pixel after segment beat");

	// Pixels before the last are followed by more.
	a_more_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_pixel |=> out_valid)
		else $error("segment ended without last pixel");

	// A new segment is taken only when no pixel is pending or the last leaves.
	a_in_gate: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid || (out_ready && last_pixel))
		else $error("segment accepted with pixels pending");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("pixel dropped under stall");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable(pixel_x) && $stable(pixel_y) && $stable(last_pixel))
		else $error("pixel changed under stall");

endmodule

bind bresenham_line_rasterizer brl_chk u_brl_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (seg.valid),
	.in_ready   (seg.ready),
	.out_valid  (pix.valid),
	.out_ready  (pix.ready),
	.pixel_x    (pix.pixel_x),
	.pixel_y    (pix.pixel_y),
	.last_pixel (pix.last_pixel)
);
`default_nettype wire

FILE: sim/tb_bresenham_line_rasterizer.sv
`timescale 1ns / 100ps

module tb_bresenham_line_rasterizer;

	// Coordinates are FIELD_W bits wide on both channels.
	typedef logic [brl_pkg::FIELD_W-1:0] coord_t;

	// One segment beat on the seg channel.
	typedef struct packed {
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
	} segment_t;

	// One pixel beat on the pix channel.
	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   last;
	} pixel_t;

	localparam int unsigned MAX_REPORTS  = 10;
	// A segment holds the block for at most 64 pixels; wait a bit longer than
	// that after the last expected pixel before declaring the run clean.
	localparam int unsigned DRAIN_SLACK  = 80;
	// Receiver hold-off used to back the block up into the seg channel.
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned N_DIRECTED   = 23;
	localparam int unsigned N_RANDOM     = 200;
	localparam int unsigned N_BACKPRESS  = 12;

	// Expected pixel stream. Every accepted segment is walked here with the
	// integer Bresenham rule and its pixels are queued in order; the monitor
	// pops one per accepted pixel beat.
	class pixel_scoreboard;
		pixel_t      pending_pixels[$];
		int unsigned mismatches = 0;

		function int unsigned outstanding();
			return pending_pixels.size();
		endfunction

		function void note_segment(segment_t s);
			int     x0, y0, x1, y1;
			int     span_x, span_y, step_x, step_y;
			int     major, minor, cx, cy, err;
			bit     x_major;
			pixel_t p;
			// COORD_BITS equals the field width, so no masking is needed.
			x0 = s.sx;
			y0 = s.sy;
			x1 = s.ex;
			y1 = s.ey;
			span_x  = (x1 > x0) ? x1 - x0 : x0 - x1;
			span_y  = (y1 > y0) ? y1 - y0 : y0 - y1;
			step_x  = (x0 < x1) ? 1 : -1;
			step_y  = (y0 < y1) ? 1 : -1;
			// ties go to x
			x_major = (span_x >= span_y);
			major   = x_major ? span_x : span_y;
			minor   = x_major ? span_y : span_x;
			cx  = x0;
			cy  = y0;
			err = 2 * minor - major;
			for (int i = 0; i <= major; i++) begin
				p.x    = coord_t'(cx);
				p.y    = coord_t'(cy);
				p.last = (i == major);
				pending_pixels = {pending_pixels, p};
				if (err >= 0) begin
					if (x_major)
						cy += step_y;
					else
						cx += step_x;
					err -= 2 * major;
				end
				if (x_major)
					cx += step_x;
				else
					cy += step_y;
				err += 2 * minor;
			end
		endfunction

		function void check_pixel(coord_t x, coord_t y, logic last);
			pixel_t want;
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected pixel (%0d,%0d) last=%0b", $time, x, y, last);
				return;
			end
			want = pending_pixels.pop_front();
			if (want.x !== x || want.y !== y || want.last !== last) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display({"%0t: pixel mismatch: expected (%0d,%0d) last=%0b, ",
						"got (%0d,%0d) last=%0b"},
						$time, want.x, want.y, want.last, x, y, last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	brl_seg_if seg_ch ();
	brl_pix_if pix_ch ();

	pixel_scoreboard sb = new();

	// Set by the stimulus to ask the receiver for one long hold-off.
	bit hold_req = 1'b0;

	int unsigned rx_run_left  = 0;
	int unsigned rx_idle_left = 0;

	always #6 clk = ~clk;

	bresenham_line_rasterizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.seg    (seg_ch),
		.pix    (pix_ch)
	);

	// Corner cases: zero-length points at both corners, full-tile horizontal,
	// vertical and diagonal runs in both directions, one segment per octant,
	// an equal-span tie, a two-pixel line, near-vertical and near-horizontal
	// full spans, and alternating bit patterns on every field.
	segment_t directed_segs [N_DIRECTED] = '{
		'{6'd0,  6'd0,  6'd0,  6'd0},
		'{6'd63, 6'd63, 6'd63, 6'd63},
		'{6'd0,  6'd0,  6'd63, 6'd0},
		'{6'd63, 6'd63, 6'd0,  6'd63},
		'{6'd0,  6'd0,  6'd0,  6'd63},
		'{6'd63, 6'd63, 6'd63, 6'd0},
		'{6'd0,  6'd0,  6'd63, 6'd63},
		'{6'd63, 6'd63, 6'd0,  6'd0},
		'{6'd0,  6'd63, 6'd63, 6'd0},
		'{6'd63, 6'd0,  6'd0,  6'd63},
		'{6'd10, 6'd10, 6'd20, 6'd13},
		'{6'd20, 6'd13, 6'd10, 6'd10},
		'{6'd10, 6'd10, 6'd13, 6'd20},
		'{6'd13, 6'd20, 6'd10, 6'd10},
		'{6'd10, 6'd10, 6'd20, 6'd7},
		'{6'd20, 6'd7,  6'd10, 6'd10},
		'{6'd10, 6'd10, 6'd7,  6'd20},
		'{6'd7,  6'd20, 6'd10, 6'd10},
		'{6'd5,  6'd5,  6'd8,  6'd2},
		'{6'd30, 6'd30, 6'd31, 6'd30},
		'{6'd0,  6'd0,  6'd1,  6'd63},
		'{6'd63, 6'd0,  6'd0,  6'd1},
		'{6'd42, 6'd21, 6'd21, 6'd42}
	};

	// Gap length for either side: mostly none or a few cycles, now and then
	// a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(40, 120);
	endfunction

	// Present one segment and hold it until the block takes it. valid is
	// left high so back-to-back beats need no second assignment.
	task automatic send_segment(input segment_t s);
		seg_ch.valid   <= 1'b1;
		seg_ch.start_x <= s.sx;
		seg_ch.start_y <= s.sy;
		seg_ch.end_x   <= s.ex;
		seg_ch.end_y   <= s.ey;
		do
			@(posedge clk);
		while (!seg_ch.ready);
		sb.note_segment(s);
	endtask

	task automatic sender_gap();
		int unsigned n;
		n = pick_gap();
		if (n > 0) begin
			seg_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stop offering and let every expected pixel come out.
	task automatic wait_drained();
		seg_ch.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// Random segment shapes: arbitrary endpoints most often, plus short lines
	// around the start point, axis-aligned runs, exact diagonals and points.
	task automatic send_random_segment();
		segment_t    s;
		int unsigned kind;
		coord_t      a, b;
		kind = $urandom_range(0, 9);
		s.sx = coord_t'($urandom_range(0, 63));
		s.sy = coord_t'($urandom_range(0, 63));
		s.ex = coord_t'($urandom_range(0, 63));
		s.ey = coord_t'($urandom_range(0, 63));
		if (kind >= 4 && kind <= 6) begin
			// short span; wraps at the tile edge into an occasional long one
			s.ex = s.sx + coord_t'($urandom_range(0, 8)) - coord_t'(4);
			s.ey = s.sy + coord_t'($urandom_range(0, 8)) - coord_t'(4);
		end else if (kind == 7) begin
			if ($urandom_range(0, 1))
				s.ey = s.sy;
			else
				s.ex = s.sx;
		end else if (kind == 8) begin
			a = coord_t'($urandom_range(0, 63));
			b = coord_t'($urandom_range(0, 63));
			s.sx = a;
			s.ex = b;
			if ($urandom_range(0, 1)) begin
				s.sy = a;
				s.ey = b;
			end else begin
				s.sy = ~a;
				s.ey = ~b;
			end
		end else if (kind == 9) begin
			s.ex = s.sx;
			s.ey = s.sy;
		end
		send_segment(s);
	endtask

	// Receiver: checks every accepted pixel beat, then sets ready for the
	// next edge. Runs of ready alternate with gaps; a hold request forces one
	// long stretch of ready low so the block backs up into the seg channel.
	initial begin
		pix_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (pix_ch.valid && pix_ch.ready)
				sb.check_pixel(pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.last_pixel);
			if (hold_req) begin
				hold_req     = 1'b0;
				rx_run_left  = 0;
				rx_idle_left = LONG_HOLD;
			end
			if (rx_run_left > 0) begin
				rx_run_left--;
				pix_ch.ready <= 1'b1;
			end else if (rx_idle_left > 0) begin
				rx_idle_left--;
				pix_ch.ready <= 1'b0;
			end else begin
				// occasional long run with no stalls at all
				rx_run_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
				                                          : $urandom_range(0, 8);
				rx_idle_left = pick_gap();
				pix_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		arst_n         = 1'b0;
		seg_ch.valid   = 1'b0;
		seg_ch.start_x = '0;
		seg_ch.start_y = '0;
		seg_ch.end_x   = '0;
		seg_ch.end_y   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			send_segment(directed_segs[i]);
			sender_gap();
		end
		wait_drained();

		// Back-pressure: receiver stalls for a long time while segments keep
		// coming with no gaps, so seg.ready has to drop.
		hold_req = 1'b1;
		for (int i = 0; i < N_BACKPRESS; i++)
			send_random_segment();

		for (int i = 0; i < N_RANDOM; i++) begin
			send_random_segment();
			sender_gap();
			// mid-run pause with the pipe empty
			if (i == N_RANDOM / 2)
				wait_drained();
		end
		wait_drained();

		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run (every segment 64 pixels,
	// every pixel behind the longest receiver stall).
	initial begin
		#100_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
